[hw/rtl/onee_pkg.sv]
`default_nettype none
package onee_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SPD_LOAD,
    ST_SPD_DIV,
    ST_FD_MUL,
    ST_FD_LOAD,
    ST_NORM,
    ST_ALPHA_DIV,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_FIN,
    ST_BOOST_A,
    ST_BOOST_B,
    ST_BOOST_C,
    ST_OUTPUT
  } state_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_MIN_CUTOFF   = 2'd0;
  localparam cfg_index_t CFG_SPEED_GAIN   = 2'd1;
  localparam cfg_index_t CFG_DERIV_CUTOFF = 2'd2;

  localparam logic [31:0] MIN_CUTOFF_RST   = 32'h0001_0000;
  localparam logic [31:0] SPEED_GAIN_RST   = 32'h0000_0000;
  localparam logic [31:0] DERIV_CUTOFF_RST = 32'h0001_0000;

  // round(2^16 * 1e6 / (2*pi))
  localparam logic [33:0] HZ_US_TO_TAU = 34'd10430378350;
  localparam logic [32:0] US_PER_S     = 33'd1000000;
  localparam logic [47:0] SPEED_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SPEED_MIN    = 48'h8000_0000_0000;
  localparam logic [65:0] ROUND_HALF   = 66'h0_8000_0000;

  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/onee_if.sv]
`default_nettype none
interface onee_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic        [31:0] time_us;
  logic               restart;
  modport source (output valid, sample, time_us, restart, input ready);
  modport sink   (input valid, sample, time_us, restart, output ready);
endinterface

interface onee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] smoothed;
  modport source (output valid, smoothed, input ready);
  modport sink   (input valid, smoothed, output ready);
endinterface

interface onee_cfg_if;
  logic                  valid;
  logic                  ready;
  onee_pkg::cfg_index_t  index;
  logic           [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/onee_mul.sv]
`default_nettype none
// 33x33 unsigned multiplier, product registered.
module onee_mul (
  input  logic               clk,
  input  onee_pkg::mul_req_t req,
  output logic        [65:0] p
);

  always_ff @(posedge clk) begin
    p <= 66'(req.a) * 66'(req.b);
  end

endmodule
`default_nettype wire

[hw/rtl/onee_div.sv]
`default_nettype none
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module onee_div (
  input  logic               clk,
  input  logic               rst,
  input  onee_pkg::div_req_t req,
  output onee_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] divisor;
  logic [32:0] shifted;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    shifted = {rem, quo[63]};
    trial   = {1'b0, shifted} - {2'b00, divisor};
    ge      = !trial[33];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '1;
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? trial[31:0] : shifted[31:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

[hw/rtl/one_euro_adaptive_smoother.sv]
`default_nettype none
// Channel   Dir  Payload                           Handshake
// samples   in   sample, time_us, restart           valid/ready
// results   out  smoothed                          valid/ready
// cfg       in   index, data (0 min_cutoff,         valid/ready, always ready
//                1 speed_gain, 2 derivative_cutoff)
//
// A first or restart item goes straight to the output state; any other item
// runs three divider passes (speed, two alphas), every alpha needs normalising
// shifts before its divide, and the multiplies and sequencing come on top.
// Reset clears primed and the output valid and loads the config defaults; the
// first item loads the filter state, so there is no clearing pass.
// samples.ready is high only while idle. A finished item waits in the output
// register; the next item is taken while it waits.
module one_euro_adaptive_smoother (
  input  logic       clk,
  input  logic       rst,
  onee_in_if.sink    samples,
  onee_out_if.source results,
  onee_cfg_if.sink   cfg
);

  onee_pkg::state_t   state, state_next;
  onee_pkg::mul_req_t mul_req;
  onee_pkg::div_req_t div_req;
  onee_pkg::div_rsp_t div_rsp;
  logic [65:0]        p;

  // config
  logic [31:0] min_cutoff, speed_gain, derivative_cutoff;

  // filter state
  logic        primed;
  logic [31:0] last_smoothed;
  logic [47:0] last_speed;
  logic [31:0] last_time;

  // per-item working registers
  logic [31:0] x;
  logic [31:0] dt;
  logic        neg;
  logic [47:0] speed;
  logic        pass2;      // second pass: position filter
  logic [63:0] n;
  logic [33:0] c;
  logic [32:0] alpha;
  logic        sc_neg;
  logic [47:0] m;
  logic [33:0] rlo;
  logic [63:0] acc;
  logic [31:0] cut;

  logic        out_valid;
  logic [31:0] out_value;

  // combinational helpers
  logic [32:0] diff_x, mag_x;
  logic [48:0] diff_s, sc_d, sc_mag;
  logic [64:0] sum_nc;
  logic        nc_fits;
  logic [47:0] speed_sat, s_abs;
  logic [65:0] cut_wide;
  logic [31:0] cut_sat;
  logic [65:0] lo_round;
  logic [49:0] r50, sr;
  logic [49:0] speed_sum, pos_sum;
  logic [31:0] dt_raw;
  logic        accept;

  onee_mul u_mul (.clk(clk), .req(mul_req), .p(p));
  onee_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign accept = samples.valid && samples.ready;
  assign dt_raw = samples.time_us - last_time;

  always_comb begin
    diff_x  = {x[31], x} - {last_smoothed[31], last_smoothed};
    mag_x   = diff_x[32] ? 33'd0 - diff_x : diff_x;
    diff_s  = {speed[47], speed} - {last_speed[47], last_speed};
    sc_d    = pass2 ? {{16{diff_x[32]}}, diff_x} : diff_s;
    sc_mag  = sc_d[48] ? 49'd0 - sc_d : sc_d;
    sum_nc  = {1'b0, n} + {31'd0, c};
    nc_fits = (sum_nc[64:32] == '0);
    s_abs   = last_speed[47] ? 48'd0 - last_speed : last_speed;

    // saturate the raw speed to signed 48 bits
    if (neg) begin
      speed_sat = (div_rsp.quotient > 64'h0000_8000_0000_0000) ? onee_pkg::SPEED_MIN
                                                               : 48'd0 - div_rsp.quotient[47:0];
    end else begin
      speed_sat = (div_rsp.quotient > 64'h0000_7FFF_FFFF_FFFF) ? onee_pkg::SPEED_MAX
                                                               : div_rsp.quotient[47:0];
    end

    // cutoff = min_cutoff + gain*|speed|, saturating at all ones
    cut_wide = {2'b00, acc} + 66'(p[65:16]) + 66'(min_cutoff);
    cut_sat  = (cut_wide[65:32] != '0) ? 32'hFFFF_FFFF : cut_wide[31:0];

    // scaling by alpha: low half rounded half up, then high half added
    lo_round  = p + onee_pkg::ROUND_HALF;
    r50       = p[49:0] + 50'(rlo);
    sr        = sc_neg ? 50'd0 - r50 : r50;
    speed_sum = {{2{last_speed[47]}}, last_speed} + sr;
    pos_sum   = {{18{last_smoothed[31]}}, last_smoothed} + sr;
  end

  // sequencer: next state, unit requests, handshake
  always_comb begin
    state_next       = state;
    samples.ready    = 1'b0;
    mul_req          = '0;
    div_req          = '0;
    unique case (state)
      onee_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = (!primed || samples.restart) ? onee_pkg::ST_OUTPUT
                                                    : onee_pkg::ST_DIFF;
        end
      end
      onee_pkg::ST_DIFF: begin
        mul_req.a  = mag_x;
        mul_req.b  = onee_pkg::US_PER_S;
        state_next = onee_pkg::ST_SPD_LOAD;
      end
      onee_pkg::ST_SPD_LOAD: begin
        div_req.start    = 1'b1;
        div_req.dividend = p[63:0];
        div_req.divisor  = dt;
        state_next       = onee_pkg::ST_SPD_DIV;
      end
      onee_pkg::ST_SPD_DIV: begin
        if (div_rsp.done) state_next = onee_pkg::ST_FD_MUL;
      end
      onee_pkg::ST_FD_MUL: begin
        mul_req.a  = {1'b0, pass2 ? cut : derivative_cutoff};
        mul_req.b  = {1'b0, dt};
        state_next = onee_pkg::ST_FD_LOAD;
      end
      onee_pkg::ST_FD_LOAD: begin
        state_next = onee_pkg::ST_NORM;
      end
      onee_pkg::ST_NORM: begin
        if (nc_fits) begin
          div_req.start    = 1'b1;
          div_req.dividend = {n[31:0], 32'd0};
          div_req.divisor  = sum_nc[31:0];
          state_next       = onee_pkg::ST_ALPHA_DIV;
        end
      end
      onee_pkg::ST_ALPHA_DIV: begin
        if (div_rsp.done) state_next = onee_pkg::ST_SC_LO;
      end
      onee_pkg::ST_SC_LO: begin
        mul_req.a  = {1'b0, m[31:0]};
        mul_req.b  = alpha;
        state_next = onee_pkg::ST_SC_HI;
      end
      onee_pkg::ST_SC_HI: begin
        mul_req.a  = {17'd0, m[47:32]};
        mul_req.b  = alpha;
        state_next = onee_pkg::ST_SC_FIN;
      end
      onee_pkg::ST_SC_FIN: begin
        state_next = pass2 ? onee_pkg::ST_OUTPUT : onee_pkg::ST_BOOST_A;
      end
      onee_pkg::ST_BOOST_A: begin
        mul_req.a  = {1'b0, speed_gain};
        mul_req.b  = {1'b0, s_abs[47:16]};
        state_next = onee_pkg::ST_BOOST_B;
      end
      onee_pkg::ST_BOOST_B: begin
        mul_req.a  = {1'b0, speed_gain};
        mul_req.b  = {17'd0, s_abs[15:0]};
        state_next = onee_pkg::ST_BOOST_C;
      end
      onee_pkg::ST_BOOST_C: begin
        state_next = onee_pkg::ST_FD_MUL;
      end
      onee_pkg::ST_OUTPUT: begin
        if (!out_valid || results.ready) state_next = onee_pkg::ST_IDLE;
      end
      default: state_next = onee_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= onee_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff        <= onee_pkg::MIN_CUTOFF_RST;
      speed_gain        <= onee_pkg::SPEED_GAIN_RST;
      derivative_cutoff <= onee_pkg::DERIV_CUTOFF_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        onee_pkg::CFG_MIN_CUTOFF:   min_cutoff        <= cfg.data;
        onee_pkg::CFG_SPEED_GAIN:   speed_gain        <= cfg.data;
        onee_pkg::CFG_DERIV_CUTOFF: derivative_cutoff <= cfg.data;
        default: ;
      endcase
    end
  end

  // control state under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) primed <= 1'b1;
      if (state == onee_pkg::ST_OUTPUT && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      onee_pkg::ST_IDLE: begin
        if (accept) begin
          x         <= samples.sample;
          last_time <= samples.time_us;
          dt        <= (dt_raw == '0) ? 32'd1 : dt_raw;
          if (!primed || samples.restart) begin
            last_smoothed <= samples.sample;
            last_speed    <= '0;
          end
        end
      end
      onee_pkg::ST_DIFF: neg <= diff_x[32];
      onee_pkg::ST_SPD_DIV: begin
        if (div_rsp.done) begin
          speed <= speed_sat;
          pass2 <= 1'b0;
        end
      end
      onee_pkg::ST_FD_LOAD: begin
        n <= p[63:0];
        c <= onee_pkg::HZ_US_TO_TAU;
      end
      onee_pkg::ST_NORM: begin
        if (!nc_fits) begin
          n <= n >> 1;
          c <= c >> 1;
        end
      end
      onee_pkg::ST_ALPHA_DIV: begin
        if (div_rsp.done) begin
          alpha  <= div_rsp.quotient[32:0];
          m      <= sc_mag[47:0];
          sc_neg <= sc_d[48];
        end
      end
      onee_pkg::ST_SC_HI: rlo <= lo_round[65:32];
      onee_pkg::ST_SC_FIN: begin
        if (pass2) last_smoothed <= pos_sum[31:0];
        else       last_speed    <= speed_sum[47:0];
      end
      onee_pkg::ST_BOOST_B: acc <= p[63:0];
      onee_pkg::ST_BOOST_C: begin
        cut   <= cut_sat;
        pass2 <= 1'b1;
      end
      onee_pkg::ST_OUTPUT: begin
        if (!out_valid || results.ready) out_value <= last_smoothed;
      end
      default: ;
    endcase
  end

  assign results.valid    = out_valid;
  assign results.smoothed = out_value;

endmodule
`default_nettype wire
